@@ hdl/fpa_pkg.sv @@
`timescale 1ns / 1ps
package fpa_pkg;
	localparam int FRAC_BITS = 8;
	localparam int QW = 32 + FRAC_BITS + 1;
	localparam int NSTEP = QW;

	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_SUB = 4'd1;
	localparam logic [3:0] OP_MUL = 4'd2;
	localparam logic [3:0] OP_DIV = 4'd3;
	localparam logic [3:0] OP_GT = 4'd4;
	localparam logic [3:0] OP_LT = 4'd5;
	localparam logic [3:0] OP_GE = 4'd6;
	localparam logic [3:0] OP_LE = 4'd7;
	localparam logic [3:0] OP_EQ = 4'd8;
	localparam logic [3:0] OP_NE = 4'd9;
	localparam logic [3:0] OP_MIN = 4'd10;
	localparam logic [3:0] OP_MAX = 4'd11;
	localparam logic [3:0] OP_INC = 4'd12;
	localparam logic [3:0] OP_DEC = 4'd13;
	localparam logic [3:0] OP_I2F = 4'd14;
	localparam logic [3:0] OP_F2I = 4'd15;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DIV0 = 2'd1;
	localparam logic [1:0] ST_OVF = 2'd2;

	// one slot of the cell chain
	typedef struct packed {
		logic        vld;
		logic        is_div;
		logic        neg;
		logic [1:0]  st;
		logic        cmp;
		logic [31:0] res;      // finished result for non-divide operations
		logic [QW:0] rem;      // partial remainder (2n numerator scheme)
		logic [QW-1:0] num;    // numerator bits still to shift in
		logic [QW-1:0] quo;    // quotient bits so far
		logic [32:0] den;      // 2*|b|
	} slot_t;
endpackage

@@ hdl/fpa_cell.sv @@
`timescale 1ns / 1ps
module fpa_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  fpa_pkg::slot_t  din,
	output fpa_pkg::slot_t  dout
);
	fpa_pkg::slot_t nx;
	logic [fpa_pkg::QW:0] sh;

	// one restoring-division step; other slots pass through
	always_comb begin
		nx = din;
		sh = {din.rem[fpa_pkg::QW-1:0], din.num[fpa_pkg::QW-1]};
		if (din.is_div) begin
			nx.num = {din.num[fpa_pkg::QW-2:0], 1'b0};
			if (sh >= {{(fpa_pkg::QW-32){1'b0}}, din.den}) begin
				nx.rem = sh - {{(fpa_pkg::QW-32){1'b0}}, din.den};
				nx.quo = {din.quo[fpa_pkg::QW-2:0], 1'b1};
			end else begin
				nx.rem = sh;
				nx.quo = {din.quo[fpa_pkg::QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout <= nx;
		end
	end
endmodule

@@ hdl/fixed_point_alu.sv @@
`timescale 1ns / 1ps
// Signed 32-bit fixed-point ALU, FRAC_BITS fraction bits, no state.
// Input channel s_axis: tuser = operation code, tdata = {operand_b, operand_a}.
// Output channel m_axis: tdata = {compare_true, result_value} padded to 40 bits,
// tuser = status.
// Every transaction passes a front stage register (decode, compare, wrap ops,
// multiply product), then a chain of one cell per quotient bit (FRAC_BITS+33
// cells, one restoring-division step each), then rounding/saturation logic that
// feeds the output register. Every operation passes the same registers,
// so results leave in order. Throughput is one transaction per cycle unless stalled.
// The whole pipeline advances together: it stalls only when the output
// register holds a result the receiver has not taken, so s_axis_tready
// follows that. The multiply product is registered before it is rounded.
// Reset clears the pipeline registers and the output valid; the output
// payload is not reset.
// Divide: quotient = floor((2*|a|<<F + |b|) / (2*|b|)), i.e. half away from
// zero; division by zero returns 0 with status 1.
module fixed_point_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [31:0] operand_a, [63:32] operand_b
	input  logic [3:0]  s_axis_tuser,  // [3:0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [31:0] result_value, [32] compare_true
	output logic [1:0]  m_axis_tuser   // [1:0] status
);
	localparam int F = fpa_pkg::FRAC_BITS;
	localparam int QW = fpa_pkg::QW;
	localparam int N = fpa_pkg::NSTEP;
	localparam int PQW = 65 - F;

	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	logic [3:0] op;
	logic signed [31:0] a, b;
	assign op = s_axis_tuser;
	assign a = s_axis_tdata[31:0];
	assign b = s_axis_tdata[63:32];

	// front stage
	fpa_pkg::slot_t s0;
	logic [31:0] ma, mb;
	logic lt, eq;
	assign ma = a[31] ? (32'd0 - a) : a;
	assign mb = b[31] ? (32'd0 - b) : b;
	assign lt = a < b;
	assign eq = a == b;

	always_comb begin
		s0 = '0;
		s0.vld = s_axis_tvalid;
		s0.st = fpa_pkg::ST_OK;
		s0.neg = a[31] ^ b[31];
		s0.den = {mb, 1'b0};
		s0.num = {ma, {(F+1){1'b0}}};
		case (op)
			fpa_pkg::OP_ADD: s0.res = a + b;
			fpa_pkg::OP_SUB: s0.res = a - b;
			fpa_pkg::OP_GT: s0.cmp = !lt && !eq;
			fpa_pkg::OP_LT: s0.cmp = lt;
			fpa_pkg::OP_GE: s0.cmp = !lt;
			fpa_pkg::OP_LE: s0.cmp = lt || eq;
			fpa_pkg::OP_EQ: s0.cmp = eq;
			fpa_pkg::OP_NE: s0.cmp = !eq;
			fpa_pkg::OP_MIN: s0.res = lt ? a : b;
			fpa_pkg::OP_MAX: s0.res = (!lt && !eq) ? a : b;
			fpa_pkg::OP_INC: s0.res = a + 32'd1;
			fpa_pkg::OP_DEC: s0.res = a - 32'd1;
			fpa_pkg::OP_I2F: s0.res = a << F;
			fpa_pkg::OP_F2I: s0.res = a >>> F;
			fpa_pkg::OP_DIV: begin
				if (b == 32'sd0) s0.st = fpa_pkg::ST_DIV0;
				else s0.is_div = 1'b1;
			end
			default: ;
		endcase
	end

	// multiply: product registered alongside the front stage slot
	logic signed [63:0] prod_s1;
	logic mul_s1;
	fpa_pkg::slot_t head_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_s1 <= '0;
			prod_s1 <= '0;
			mul_s1 <= 1'b0;
		end else if (en) begin
			head_s1 <= s0;
			prod_s1 <= a * b;
			mul_s1 <= (op == fpa_pkg::OP_MUL);
		end
	end

	// multiply rounding, one register after product
	logic [63:0] pm;
	logic [64:0] pr;
	logic [PQW-1:0] pq;
	assign pm = prod_s1[63] ? (64'd0 - prod_s1) : prod_s1;
	assign pr = {1'b0, pm} + (65'd1 << (F-1));
	assign pq = pr[64:F];

	fpa_pkg::slot_t mul_slot;
	always_comb begin
		mul_slot = head_s1;
		if (mul_s1) begin
			if (!prod_s1[63] && pq > PQW'(32'h7FFFFFFF)) begin
				mul_slot.res = 32'h7FFFFFFF; mul_slot.st = fpa_pkg::ST_OVF;
			end else if (prod_s1[63] && pq > PQW'(32'h80000000)) begin
				mul_slot.res = 32'h80000000; mul_slot.st = fpa_pkg::ST_OVF;
			end else begin
				mul_slot.res = prod_s1[63] ? (32'd0 - pq[31:0]) : pq[31:0];
			end
		end
	end

	// division chain: first cell also receives mul result
	fpa_pkg::slot_t chain [0:N];
	assign chain[0] = mul_slot;

	genvar gi;
	generate
		for (gi = 0; gi < N; gi++) begin : g_cell
			fpa_cell u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.din(chain[gi]),
				.dout(chain[gi+1])
			);
		end
	endgenerate

	// quotient = floor((2n + d)/(2d)) = floor(n/d + 1/2): round using remainder
	fpa_pkg::slot_t t;
	logic [QW:0] q;
	logic up;
	assign t = chain[N];
	// chain computed floor(2n/(2d)) with 2n; remainder r, round up if 2r >= d'
	assign up = {t.rem, 1'b0} >= {1'b0, {(QW-32){1'b0}}, t.den};
	assign q = {1'b0, t.quo} + {{QW{1'b0}}, up};

	logic [31:0] ores;
	logic [1:0] ost;
	always_comb begin
		ores = t.res;
		ost = t.st;
		if (t.is_div) begin
			if (!t.neg && q > (QW+1)'(32'h7FFFFFFF)) begin
				ores = 32'h7FFFFFFF; ost = fpa_pkg::ST_OVF;
			end else if (t.neg && q > (QW+1)'(32'h80000000)) begin
				ores = 32'h80000000; ost = fpa_pkg::ST_OVF;
			end else begin
				ores = t.neg ? (32'd0 - q[31:0]) : q[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= t.vld;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {7'd0, t.cmp, ores};
			m_axis_tuser <= ost;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken during output stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != 2'd3)
		else $error("bad status");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == fpa_pkg::ST_DIV0 |-> m_axis_tdata[32:0] == 33'd0)
		else $error("div0 result not zero");
endmodule

@@ bench/tb_fixed_point_alu.sv @@
`timescale 1ns / 1ps
module tb_fixed_point_alu;
	localparam int LATENCY = fpa_pkg::FRAC_BITS + 34;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [31:0] value;
		logic        cmp;
		logic [1:0]  st;
	} alu_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;  // [31:0] operand_a, [63:32] operand_b
	logic [3:0]  s_axis_tuser = '0;  // [3:0] operation
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;       // [31:0] result_value, [32] compare_true
	logic [1:0]  m_axis_tuser;       // [1:0] status

	alu_result_t expected_results[$];
	int  mismatch_count = 0;
	int  sent_count = 0;
	int  checked_count = 0;
	int  idle_cycles = 0;
	int  stall_left = 0;
	bit  sender_idling = 1'b1;
	bit  receiver_idling = 1'b1;
	bit  hold_off = 1'b0;

	fixed_point_alu dut (.*);

	always #10 clk = ~clk;

	// Saturate a rounded magnitude into signed 32 bits.
	function automatic alu_result_t sat_signed(logic [63:0] mag, bit neg);
		alu_result_t r;
		r = '0;
		if (!neg) begin
			if (mag > 64'h7FFF_FFFF) begin
				r.value = 32'h7FFF_FFFF;
				r.st = fpa_pkg::ST_OVF;
			end else
				r.value = mag[31:0];
		end else begin
			if (mag > 64'h8000_0000) begin
				r.value = 32'h8000_0000;
				r.st = fpa_pkg::ST_OVF;
			end else
				r.value = -mag[31:0];
		end
		return r;
	endfunction

	function automatic alu_result_t predict_alu(logic [3:0] op, logic [31:0] ua,
			logic [31:0] ub);
		alu_result_t r;
		logic signed [31:0] a, b;
		logic signed [63:0] prod;
		logic [63:0] mag, num, den;
		r = '0;
		a = ua;
		b = ub;
		case (op)
			fpa_pkg::OP_ADD: r.value = ua + ub;
			fpa_pkg::OP_SUB: r.value = ua - ub;
			fpa_pkg::OP_MUL: begin
				prod = 64'(a) * 64'(b);
				mag = prod[63] ? -prod : prod;
				mag = (mag + (64'd1 << (fpa_pkg::FRAC_BITS - 1))) >> fpa_pkg::FRAC_BITS;
				r = sat_signed(mag, prod[63]);
			end
			fpa_pkg::OP_DIV: begin
				if (b == 0)
					r.st = fpa_pkg::ST_DIV0;
				else begin
					num = (a < 0 ? -64'(a) : 64'(a)) << fpa_pkg::FRAC_BITS;
					den = b < 0 ? -64'(b) : 64'(b);
					r = sat_signed((2 * num + den) / (2 * den), (a < 0) != (b < 0));
				end
			end
			fpa_pkg::OP_GT: r.cmp = a > b;
			fpa_pkg::OP_LT: r.cmp = a < b;
			fpa_pkg::OP_GE: r.cmp = a >= b;
			fpa_pkg::OP_LE: r.cmp = a <= b;
			fpa_pkg::OP_EQ: r.cmp = a == b;
			fpa_pkg::OP_NE: r.cmp = a != b;
			fpa_pkg::OP_MIN: r.value = a < b ? ua : ub;
			fpa_pkg::OP_MAX: r.value = a > b ? ua : ub;
			fpa_pkg::OP_INC: r.value = ua + 1;
			fpa_pkg::OP_DEC: r.value = ua - 1;
			fpa_pkg::OP_I2F: r.value = ua << fpa_pkg::FRAC_BITS;
			default: r.value = a >>> fpa_pkg::FRAC_BITS;
		endcase
		return r;
	endfunction

	// Offer one transaction at the falling edge, hold it until accepted.
	task automatic send_op(logic [3:0] op, logic [31:0] a, logic [31:0] b);
		int gap;
		if (sender_idling && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 17);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {b, a};
		do @(posedge clk); while (!s_axis_tready);
		expected_results.push_back(predict_alu(op, a, b));
		sent_count++;
		@(negedge clk);
	endtask

	// Operand with extremes and small values weighted in.
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			1: return 32'h8000_0000 + $urandom_range(0, 3);
			2: return $urandom_range(0, 1023) - 512;
			3: return 32'(signed'($urandom_range(0, 65535) - 32768)) << $urandom_range(0, 8);
			default: return $urandom;
		endcase
	endfunction

	// Receiver: random stall bursts, plus the long hold-off.
	always @(negedge clk) begin
		if (hold_off)
			m_axis_tready <= 1'b0;
		else if (receiver_idling && stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (receiver_idling && $urandom_range(0, 7) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= $urandom_range(0, 16);
		end else
			m_axis_tready <= 1'b1;
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		alu_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result value=%h cmp=%b st=%0d",
						m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tuser);
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tdata[31:0] !== want.value || m_axis_tdata[32] !== want.cmp ||
						m_axis_tuser !== want.st || m_axis_tdata[39:33] !== 7'd0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch #%0d: want %h/%b/%0d got %h/%b/%0d",
							checked_count, want.value, want.cmp, want.st,
							m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tuser);
				end
			end
			checked_count++;
		end
	end

	// Watchdog on cycles with no transaction on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("[fixed_point_alu] ERROR");
			$finish;
		end
	end

	task automatic test_directed();
		logic [31:0] edge_vals[6];
		edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h100, 32'hFFFF_FF00};
		for (int op = 0; op < 16; op++)
			send_op(op[3:0], edge_vals[op % 6], edge_vals[(op + 1) % 6]);
		send_op(fpa_pkg::OP_DIV, 32'h300, 32'h0);            // divide by zero
		send_op(fpa_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF); // positive saturation
		send_op(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h7FFF_FFFF); // negative saturation
		send_op(fpa_pkg::OP_DIV, 32'h8000_0000, 32'h80);     // divide overflow
		send_op(fpa_pkg::OP_MUL, 32'h1, 32'h80);             // tie rounds up
		send_op(fpa_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h80);     // negative tie away from zero
		send_op(fpa_pkg::OP_DIV, 32'h1, 32'h200);            // divide tie
		send_op(fpa_pkg::OP_MIN, 32'h55, 32'h55);            // equal operands
		send_op(fpa_pkg::OP_MAX, 32'hFFFF_FFAA, 32'hFFFF_FFAA);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			send_op(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
	endtask

	task automatic test_backpressure();
		int stall_len;
		hold_off = 1'b1;
		fork
			begin
				stall_len = 300;
				repeat (stall_len) @(negedge clk);
				hold_off = 1'b0;
			end
			test_random(LATENCY + 40);
		join
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(600);
		test_backpressure();
		test_random(400);
		sender_idling = 1'b0;
		receiver_idling = 1'b0;
		test_random(150);
		drain();
		$display("ran %0d transactions over all 16 operations, %0d results checked",
			sent_count, checked_count);
		$display("including saturation, divide by zero, rounding ties and a long output stall");
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("[fixed_point_alu] OK");
		else
			$display("[fixed_point_alu] ERROR");
		$finish;
	end
endmodule
